// File: rtl/core/line_steering_error_from_frame_assert.svh
// Assertion macros shared by the line steering error block.
// Expects clk and rst_n in the scope of every module that uses them.
`ifndef LINE_STEERING_ERROR_FROM_FRAME_ASSERT_SVH
`define LINE_STEERING_ERROR_FROM_FRAME_ASSERT_SVH
`ifndef SYNTHESIS
`define LSEF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LSEF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSEF_ASSERT_IMP(label, ante, cons)
`define LSEF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/core/lsef_pkg.sv
// Shared types and constants for the line steering error block.
// No dependencies.
package lsef_pkg;

    localparam int LSEF_BAND_COLS  = 319;
    localparam int LSEF_FRAME_ROWS = 240;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 8;
    localparam int SUM_W   = 25;
    localparam int CNT_W   = 16;
    localparam int DIR_W   = 9;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 16;

    localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_LIMIT     = 1'b1;

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd128;
    localparam logic [CNT_W-1:0] LIMIT_RST     = 16'd10000;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CROSS = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic acc_en;
        logic load;
        logic div_step;
        logic out_load;
    } lsef_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } lsef_sts_t;

endpackage

// File: rtl/core/lsef_dp.sv
// Datapath: band accumulators, configuration registers, serial divider and
// result register. Depends on lsef_pkg and the assertion header.
`include "line_steering_error_from_frame_assert.svh"
module lsef_dp #(
    parameter int BAND_COLS  = lsef_pkg::LSEF_BAND_COLS,
    parameter int FRAME_ROWS = lsef_pkg::LSEF_FRAME_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lsef_pkg::lsef_cmd_t            cmd,
    output lsef_pkg::lsef_sts_t            sts,
    input  logic [lsef_pkg::PIX_W-1:0]     pixel,
    input  logic [lsef_pkg::COL_W-1:0]     col,
    input  logic [lsef_pkg::ROW_W-1:0]     row,
    input  logic                           cfg_we,
    input  logic [lsef_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [lsef_pkg::CFG_D_W-1:0]   cfg_wdata,
    output logic [lsef_pkg::DIR_W-1:0]     direction,
    output lsef_pkg::status_t              status,
    output logic [lsef_pkg::CNT_W-1:0]     white_pixels
);
    import lsef_pkg::*;

    localparam int TAG_W   = 11;
    localparam int RowLo   = FRAME_ROWS / 4;
    localparam int RowHi   = (FRAME_ROWS / 4) * 3;
    localparam int ColMid  = BAND_COLS / 2;

    logic [PIX_W-1:0]  threshold_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    status_t           stat_reg;
    logic [CNT_W-1:0]  frame_cnt_reg;

    logic [DIR_W-1:0]  dir_reg;
    status_t           out_stat_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic [TAG_W-1:0]  col_x;
    logic [TAG_W-1:0]  row_x;
    logic              in_band;
    logic              right_half;
    logic [SUM_W-1:0]  pix_x;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  count_new;
    status_t           stat_new;
    logic [SUM_W-1:0]  mag_new;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic [DIR_W-1:0]  mag8;
    logic [DIR_W-1:0]  dir_new;

    assign col_x      = {{(TAG_W-COL_W){1'b0}}, col};
    assign row_x      = {{(TAG_W-ROW_W){1'b0}}, row};
    assign in_band    = (col_x < TAG_W'(BAND_COLS)) && (row_x >= TAG_W'(RowLo))
                        && (row_x < TAG_W'(RowHi));
    assign right_half = col_x > TAG_W'(ColMid);
    assign pix_x      = {{(SUM_W-PIX_W){1'b0}}, pixel};

    always_comb
    begin
        sum_new   = sum_reg;
        count_new = count_reg;
        if (in_band)
        begin
            if (pixel > threshold_reg && count_reg != COUNT_MAX)
                count_new = count_reg + 1'b1;
            if (right_half)
                sum_new = sum_reg + pix_x;
            else
                sum_new = sum_reg - pix_x;
        end
    end

    always_comb
    begin
        if (count_new >= limit_reg)
            stat_new = ST_CROSS;
        else if (count_new == '0)
            stat_new = ST_EMPTY;
        else
            stat_new = ST_OK;
    end

    assign mag_new = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;

    // restoring division, one quotient bit per step
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor_reg};

    // quotient mod 256 keeps the dividend's sign
    assign mag8    = {{(DIR_W-8){1'b0}}, quo_reg[7:0]};
    assign dir_new = neg_reg ? (~mag8 + 1'b1) : mag8;

    assign sts.div_done = (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            limit_reg     <= LIMIT_RST;
            sum_reg       <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            stat_reg      <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_THRESHOLD: threshold_reg <= cfg_wdata[PIX_W-1:0];
                    CFG_LIMIT:     limit_reg     <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (cmd.load)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                stat_reg  <= stat_new;
                step_reg  <= (stat_new == ST_OK) ? STEP_W'(SUM_W) : '0;
            end
            else
            begin
                if (cmd.acc_en)
                begin
                    sum_reg   <= sum_new;
                    count_reg <= count_new;
                end
                if (cmd.div_step)
                    step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg       <= mag_new;
            rem_reg       <= '0;
            divisor_reg   <= count_new;
            neg_reg       <= sum_new[SUM_W-1];
            frame_cnt_reg <= count_new;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[CNT_W])
            begin
                rem_reg <= rem_diff[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            dir_reg      <= (stat_reg == ST_OK) ? dir_new : '0;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= frame_cnt_reg;
        end
    end

    assign direction    = dir_reg;
    assign status       = out_stat_reg;
    assign white_pixels = out_cnt_reg;

    `LSEF_ASSERT_NXT(a_acc_cleared, cmd.load, (sum_reg == '0) && (count_reg == '0))
    `LSEF_ASSERT_IMP(a_div_only_ok, step_reg != '0, stat_reg == ST_OK)
    `LSEF_ASSERT_IMP(a_rem_bound, cmd.div_step, rem_reg < divisor_reg)

endmodule

// File: rtl/core/lsef_ctrl.sv
// Controller: accepts pixels, sequences the frame-end divide and owns the
// result valid flag. Depends on lsef_pkg and the assertion header.
`include "line_steering_error_from_frame_assert.svh"
module lsef_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output lsef_pkg::lsef_cmd_t cmd,
    input  lsef_pkg::lsef_sts_t sts
);
    import lsef_pkg::*;

    typedef enum logic [1:0] {
        S_ACC,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd.acc_en   = s_tvalid && (state_reg == S_ACC);
        cmd.load     = cmd.acc_en && s_tlast;
        cmd.div_step = (state_reg == S_DIV) && !sts.div_done;
        cmd.out_load = (state_reg == S_FIN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_ACC:   if (cmd.load) state_next = S_DIV;
            S_DIV:   if (sts.div_done) state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_ACC;
            default: state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_ACC;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == S_ACC);
    assign m_tvalid = m_tvalid_reg;

    `LSEF_ASSERT_NXT(a_last_starts_div, cmd.load, state_reg == S_DIV)
    `LSEF_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_tvalid_reg || m_tready)
    `LSEF_ASSERT_NXT(a_result_shown, cmd.out_load, m_tvalid_reg && state_reg == S_ACC)

endmodule

// File: rtl/core/line_steering_error_from_frame.sv
// Line steering error from a camera frame.
// Pixels are taken one per cycle while a frame streams in.
// After the pixel marked last, a one-bit-per-cycle restoring divider runs when a divide
// is needed, then the result is loaded once the output is free and result valid rises;
// no pixel is taken in that time. Reset (rst_n, async, active low) clears the
// accumulators and result valid and loads threshold 128 and limit 10000.
module line_steering_error_from_frame #(
    parameter int BAND_COLS  = lsef_pkg::LSEF_BAND_COLS,
    parameter int FRAME_ROWS = lsef_pkg::LSEF_FRAME_ROWS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // pixel[7:0], col[16:8], row[24:17]
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // direction[8:0], white_pixels[24:9]
    output logic [1:0]                   m_tuser,   // status[1:0]
    input  logic                         cfg_we,
    input  logic [lsef_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [lsef_pkg::CFG_D_W-1:0] cfg_wdata
);
    import lsef_pkg::*;

    lsef_cmd_t         cmd;
    lsef_sts_t         sts;
    logic [DIR_W-1:0]  direction;
    status_t           status;
    logic [CNT_W-1:0]  white_pixels;

    lsef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lsef_dp #(
        .BAND_COLS  (BAND_COLS),
        .FRAME_ROWS (FRAME_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pixel        (s_tdata[PIX_W-1:0]),
        .col          (s_tdata[PIX_W+COL_W-1:PIX_W]),
        .row          (s_tdata[PIX_W+COL_W+ROW_W-1:PIX_W+COL_W]),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .direction    (direction),
        .status       (status),
        .white_pixels (white_pixels)
    );

    assign m_tdata = {{(32-DIR_W-CNT_W){1'b0}}, white_pixels, direction};
    assign m_tuser = status;

endmodule
